@@ rtl/cll_pkg.sv @@
// Shared types and codes for the cursor linked list engine.
package cll_pkg;

	localparam int unsigned ACTION_BITS = 4;
	localparam int unsigned INDEX_BITS  = 10;
	localparam int unsigned VALUE_BITS  = 32;
	localparam int unsigned STATUS_BITS = 2;

	localparam logic [ACTION_BITS-1:0] ACT_NEW    = 4'd0;
	localparam logic [ACTION_BITS-1:0] ACT_INSERT = 4'd1;
	localparam logic [ACTION_BITS-1:0] ACT_FIND   = 4'd2;
	localparam logic [ACTION_BITS-1:0] ACT_PREV   = 4'd3;
	localparam logic [ACTION_BITS-1:0] ACT_REMOVE = 4'd4;
	localparam logic [ACTION_BITS-1:0] ACT_FIRST  = 4'd5;
	localparam logic [ACTION_BITS-1:0] ACT_READ   = 4'd6;
	localparam logic [ACTION_BITS-1:0] ACT_EMPTY  = 4'd7;
	localparam logic [ACTION_BITS-1:0] ACT_DELETE = 4'd8;

	localparam logic [STATUS_BITS-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_BITS-1:0] ST_FULL = 2'd1;
	localparam logic [STATUS_BITS-1:0] ST_NULL = 2'd2;

	typedef struct packed {
		logic [ACTION_BITS-1:0] action;
		logic [INDEX_BITS-1:0]  list_head;
		logic [INDEX_BITS-1:0]  position;
		logic [VALUE_BITS-1:0]  value;
	} req_t;

	typedef struct packed {
		logic [INDEX_BITS-1:0]  node;
		logic [VALUE_BITS-1:0]  element;
		logic                   found;
		logic                   empty_res;
		logic [STATUS_BITS-1:0] status;
	} rsp_t;

endpackage

@@ rtl/cursor_linked_list_engine.sv @@
// Cursor linked list engine: shared node pool with free list, sequenced over two memories.
//
// After reset the engine sweeps the next-pointer memory once to build the free
// list, one entry a cycle, with busy high until the sweep ends. A request is
// taken when start is high and busy is low; exactly one response follows, marked
// by done for one cycle, and the receiver cannot stall it. Each cycle allows one
// read and one write of the next-pointer memory, whose read data is registered,
// so that port sets the timing. Find, find previous and remove walk the list
// node by node; remove then unlinks the match and returns it to the free list.
// Make empty returns the list's nodes to the free list one by one, and delete
// list then frees the head node too.
module cursor_linked_list_engine #(
	parameter int unsigned POOL_NODES   = 1024,
	parameter int unsigned ELEMENT_BITS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  cll_pkg::req_t  req,
	output logic           busy,
	output logic           done,
	output cll_pkg::rsp_t  rsp
);

	localparam int unsigned IW = $clog2(POOL_NODES);
	localparam int unsigned SW = $clog2(POOL_NODES + 2);
	localparam int unsigned CW = $clog2(POOL_NODES + 1);

	typedef enum logic [21:0] {
		S_IDLE   = 22'h000001,
		S_INIT   = 22'h000002,
		S_A_RD0  = 22'h000004,
		S_A_CHK  = 22'h000008,
		S_A_UNL  = 22'h000010,
		S_A_NEW  = 22'h000020,
		S_I_LINK = 22'h000040,
		S_I_POS  = 22'h000080,
		S_W_RD   = 22'h000100,
		S_W_N    = 22'h000200,
		S_W_E    = 22'h000400,
		S_R_WR   = 22'h000800,
		S_E_RD   = 22'h001000,
		S_E_CHK  = 22'h002000,
		S_P_RD   = 22'h004000,
		S_P_CHK  = 22'h008000,
		S_C_RD   = 22'h010000,
		S_C_N    = 22'h020000,
		S_C_UNL  = 22'h040000,
		S_G_RD   = 22'h080000,
		S_G_WR1  = 22'h100000,
		S_G_WR2  = 22'h200000
	} state_t;

	state_t state_q, state_d;

	logic [IW-1:0]           np_mem [POOL_NODES];
	logic [ELEMENT_BITS-1:0] el_mem [POOL_NODES];
	logic [IW-1:0]           np_rd;
	logic [ELEMENT_BITS-1:0] el_rd;
	logic                    np_we, el_we;
	logic [IW-1:0]           np_wa, np_wd, np_ra, el_wa, el_ra;

	logic [IW-1:0]                   init_q, head_q, pos_q, t_q, it_q, n_q, q_q, g_q;
	logic [ELEMENT_BITS-1:0]         val_q;
	logic [cll_pkg::ACTION_BITS-1:0] act_q;
	logic [SW-1:0]                   steps_q;
	logic [CW-1:0]                   cnt_q;
	logic                            clr_q, done_q;
	cll_pkg::rsp_t                   res_q;

	logic [IW-1:0]                   head_in, pos_in;
	logic [ELEMENT_BITS-1:0]         val_in;
	logic [cll_pkg::STATUS_BITS-1:0] st_in;
	logic                            head_null, init_last, fin, step_limit, clr_stop;

	assign head_in = (32'(req.list_head) < 32'(POOL_NODES)) ? IW'(req.list_head) : '0;
	assign pos_in  = (32'(req.position) < 32'(POOL_NODES)) ? IW'(req.position) : '0;
	assign val_in  = ELEMENT_BITS'(req.value);
	assign head_null = (head_in == '0);
	assign init_last = (init_q == IW'(POOL_NODES - 1));
	assign step_limit = (32'(steps_q) >= 32'(POOL_NODES));
	assign clr_stop = (np_rd == '0) || (32'(cnt_q) == 32'(POOL_NODES));
	assign st_in = ((req.action inside {cll_pkg::ACT_INSERT, cll_pkg::ACT_READ} &&
			pos_in == '0) ||
		(head_null && req.action inside {[cll_pkg::ACT_FIND:cll_pkg::ACT_DELETE]} &&
			req.action != cll_pkg::ACT_READ)) ? cll_pkg::ST_NULL : cll_pkg::ST_OK;

	always_comb begin
		state_d = state_q;
		fin     = 1'b0;
		np_we   = 1'b0;
		np_wa   = '0;
		np_wd   = '0;
		np_ra   = '0;
		el_we   = 1'b0;
		el_wa   = '0;
		el_ra   = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (req.action)
						cll_pkg::ACT_NEW: state_d = S_A_RD0;
						cll_pkg::ACT_INSERT: begin
							if (pos_in == '0) fin = 1'b1;
							else state_d = S_A_RD0;
						end
						cll_pkg::ACT_FIND, cll_pkg::ACT_PREV, cll_pkg::ACT_REMOVE: begin
							if (head_null) fin = 1'b1;
							else state_d = S_W_RD;
						end
						cll_pkg::ACT_FIRST: begin
							if (head_null) fin = 1'b1;
							else state_d = S_E_RD;
						end
						cll_pkg::ACT_READ: begin
							if (pos_in == '0) fin = 1'b1;
							else state_d = S_P_RD;
						end
						cll_pkg::ACT_EMPTY, cll_pkg::ACT_DELETE: begin
							if (head_null) fin = 1'b1;
							else state_d = S_C_RD;
						end
						default: fin = 1'b1;
					endcase
				end
			end
			S_INIT: begin
				np_we = 1'b1;
				np_wa = init_q;
				np_wd = init_last ? '0 : init_q + 1'b1;
				if (init_last) state_d = S_IDLE;
			end
			S_A_RD0: state_d = S_A_CHK;
			S_A_CHK: begin
				if (np_rd == '0) begin
					fin = 1'b1;
				end else begin
					np_ra   = np_rd;
					state_d = S_A_UNL;
				end
			end
			S_A_UNL: begin
				np_we = 1'b1;
				np_wd = np_rd;
				if (act_q == cll_pkg::ACT_NEW) begin
					state_d = S_A_NEW;
				end else begin
					np_ra   = pos_q;
					state_d = S_I_LINK;
				end
			end
			S_A_NEW: begin
				np_we = 1'b1;
				np_wa = t_q;
				fin   = 1'b1;
			end
			S_I_LINK: begin
				np_we   = 1'b1;
				np_wa   = t_q;
				np_wd   = np_rd;
				el_we   = 1'b1;
				el_wa   = t_q;
				state_d = S_I_POS;
			end
			S_I_POS: begin
				np_we = 1'b1;
				np_wa = pos_q;
				np_wd = t_q;
				fin   = 1'b1;
			end
			S_W_RD: begin
				np_ra   = it_q;
				state_d = S_W_N;
			end
			S_W_N: begin
				if (np_rd == '0) begin
					state_d = S_E_RD;
				end else begin
					np_ra   = np_rd;
					el_ra   = np_rd;
					state_d = S_W_E;
				end
			end
			S_W_E: begin
				if (el_rd == val_q) begin
					state_d = (act_q == cll_pkg::ACT_REMOVE) ? S_R_WR : S_E_RD;
				end else if (step_limit) begin
					state_d = S_E_RD;
				end else begin
					np_ra   = n_q;
					state_d = S_W_N;
				end
			end
			S_R_WR: begin
				np_we   = 1'b1;
				np_wa   = it_q;
				np_wd   = q_q;
				state_d = S_G_RD;
			end
			S_E_RD: begin
				np_ra   = head_q;
				state_d = S_E_CHK;
			end
			S_E_CHK: fin = 1'b1;
			S_P_RD: begin
				np_ra   = pos_q;
				el_ra   = pos_q;
				state_d = S_P_CHK;
			end
			S_P_CHK: fin = 1'b1;
			S_C_RD: begin
				np_ra   = head_q;
				state_d = S_C_N;
			end
			S_C_N: begin
				if (clr_stop) begin
					state_d = (act_q == cll_pkg::ACT_DELETE) ? S_G_RD : S_E_RD;
				end else begin
					np_ra   = np_rd;
					state_d = S_C_UNL;
				end
			end
			S_C_UNL: begin
				np_we   = 1'b1;
				np_wa   = head_q;
				np_wd   = np_rd;
				state_d = S_G_RD;
			end
			S_G_RD: state_d = S_G_WR1;
			S_G_WR1: begin
				np_we   = 1'b1;
				np_wa   = g_q;
				np_wd   = np_rd;
				state_d = S_G_WR2;
			end
			S_G_WR2: begin
				np_we = 1'b1;
				np_wd = g_q;
				if (clr_q) state_d = S_C_RD;
				else if (act_q == cll_pkg::ACT_DELETE) fin = 1'b1;
				else state_d = S_E_RD;
			end
			default: state_d = S_IDLE;
		endcase
		if (fin) state_d = S_IDLE;
	end

	always_ff @(posedge clk) begin
		if (np_we) np_mem[np_wa] <= np_wd;
		np_rd <= np_mem[np_ra];
	end

	always_ff @(posedge clk) begin
		if (el_we) el_mem[el_wa] <= val_q;
		el_rd <= el_mem[el_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			init_q  <= '0;
			done_q  <= 1'b0;
			clr_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			if (state_q == S_INIT) init_q <= init_q + 1'b1;
			if (state_q == S_IDLE && start) begin
				clr_q <= !head_null &&
					(req.action == cll_pkg::ACT_EMPTY || req.action == cll_pkg::ACT_DELETE);
			end else if (state_q == S_C_N && clr_stop) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				act_q   <= req.action;
				head_q  <= head_in;
				pos_q   <= pos_in;
				val_q   <= val_in;
				it_q    <= head_in;
				steps_q <= '0;
				cnt_q   <= '0;
				res_q   <= '{node: '0, element: '0, found: 1'b0, empty_res: 1'b0,
					status: st_in};
			end
			S_A_CHK: begin
				t_q <= np_rd;
				if (np_rd == '0) res_q.status <= cll_pkg::ST_FULL;
			end
			S_A_NEW, S_I_POS: res_q.node <= cll_pkg::INDEX_BITS'(t_q);
			S_W_N: begin
				n_q <= np_rd;
				if (np_rd == '0 && act_q != cll_pkg::ACT_FIND)
					res_q.node <= cll_pkg::INDEX_BITS'(it_q);
			end
			S_W_E: begin
				q_q <= np_rd;
				g_q <= n_q;
				if (el_rd == val_q) begin
					res_q.found <= 1'b1;
					res_q.node  <= cll_pkg::INDEX_BITS'((act_q == cll_pkg::ACT_FIND) ? n_q : it_q);
				end else if (step_limit) begin
					if (act_q != cll_pkg::ACT_FIND)
						res_q.node <= cll_pkg::INDEX_BITS'(it_q);
				end else begin
					it_q    <= n_q;
					steps_q <= steps_q + 1'b1;
				end
			end
			S_E_CHK: begin
				res_q.empty_res <= (np_rd == '0);
				if (act_q == cll_pkg::ACT_FIRST) res_q.node <= cll_pkg::INDEX_BITS'(np_rd);
			end
			S_P_CHK: begin
				res_q.node    <= cll_pkg::INDEX_BITS'(np_rd);
				res_q.element <= cll_pkg::VALUE_BITS'(el_rd);
			end
			S_C_N: g_q <= clr_stop ? head_q : np_rd;
			S_G_WR2: if (clr_q) cnt_q <= cnt_q + 1'b1;
			default: ;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = res_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("response issued while busy");
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !fin |=> busy)
		else $error("accepted request did not raise busy");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> rsp.status != 2'd3)
		else $error("undefined status code");
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status != cll_pkg::ST_OK |-> rsp.node == '0 && !rsp.found && !rsp.empty_res)
		else $error("failed request carries result data");
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_W_E |-> 32'(steps_q) <= 32'(POOL_NODES))
		else $error("walk ran past pool size");

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench for the cursor linked list engine: random list traffic checked against a pool model.
class pool_scoreboard;
	logic [9:0]  nxt[1024];
	logic [31:0] elem[1024];
	bit          live[1024];
	bit          hdr[1024];
	bit          written[1024];
	cll_pkg::rsp_t expected_rsp[$];
	cll_pkg::rsp_t last;
	int          errors;

	function new();
		for (int i = 0; i < 1024; i++) begin
			nxt[i] = (i == 1023) ? 10'd0 : 10'(i + 1);
			elem[i] = '0;
		end
		errors = 0;
	endfunction

	function logic [9:0] take_node();
		logic [9:0] p;
		p = nxt[0];
		if (p != 0) begin
			nxt[0] = nxt[p];
			live[p] = 1;
		end
		return p;
	endfunction

	function void give_node(logic [9:0] p);
		nxt[p] = nxt[0];
		nxt[0] = p;
		live[p] = 0;
		hdr[p] = 0;
	endfunction

	function logic [9:0] locate_before(logic [9:0] h, logic [31:0] v, output bit hit);
		logic [9:0] it;
		int steps;
		it = h;
		steps = 0;
		while (nxt[it] != 0 && elem[nxt[it]] != v) begin
			steps++;
			if (steps > 1024) begin
				hit = 0;
				return it;
			end
			it = nxt[it];
		end
		hit = (nxt[it] != 0);
		return it;
	endfunction

	function void clear_list(logic [9:0] h);
		logic [9:0] t;
		for (int n = 0; n < 1024 && nxt[h] != 0; n++) begin
			t = nxt[h];
			nxt[h] = nxt[t];
			give_node(t);
		end
	endfunction

	function cll_pkg::rsp_t predict_action(cll_pkg::req_t r);
		cll_pkg::rsp_t o;
		logic [9:0] h, p, t;
		bit hit;
		o = '0;
		h = r.list_head;
		hit = 0;
		if (r.action inside {cll_pkg::ACT_FIND, cll_pkg::ACT_PREV, cll_pkg::ACT_REMOVE,
				cll_pkg::ACT_FIRST, cll_pkg::ACT_EMPTY, cll_pkg::ACT_DELETE} && h == 0) begin
			o.status = cll_pkg::ST_NULL;
		end else begin
			case (r.action)
				cll_pkg::ACT_NEW: begin
					o.node = take_node();
					if (o.node == 0) o.status = cll_pkg::ST_FULL;
					else begin
						nxt[o.node] = 0;
						hdr[o.node] = 1;
					end
				end
				cll_pkg::ACT_INSERT: begin
					if (r.position == 0) o.status = cll_pkg::ST_NULL;
					else begin
						t = take_node();
						if (t == 0) o.status = cll_pkg::ST_FULL;
						else begin
							elem[t] = r.value;
							written[t] = 1;
							nxt[t] = nxt[r.position];
							nxt[r.position] = t;
							o.node = t;
						end
					end
				end
				cll_pkg::ACT_FIND: begin
					p = locate_before(h, r.value, hit);
					o.node = hit ? nxt[p] : 10'd0;
					o.found = hit;
				end
				cll_pkg::ACT_PREV: begin
					o.node = locate_before(h, r.value, hit);
					o.found = hit;
				end
				cll_pkg::ACT_REMOVE: begin
					p = locate_before(h, r.value, hit);
					o.node = p;
					if (hit) begin
						t = nxt[p];
						nxt[p] = nxt[t];
						give_node(t);
						o.found = 1;
					end
				end
				cll_pkg::ACT_FIRST: o.node = nxt[h];
				cll_pkg::ACT_READ: begin
					if (r.position == 0) o.status = cll_pkg::ST_NULL;
					else begin
						o.node = nxt[r.position];
						o.element = elem[r.position];
					end
				end
				cll_pkg::ACT_EMPTY: clear_list(h);
				cll_pkg::ACT_DELETE: begin
					clear_list(h);
					give_node(h);
				end
				default: ;
			endcase
		end
		if (o.status == cll_pkg::ST_OK && r.action inside {cll_pkg::ACT_FIND, cll_pkg::ACT_PREV,
				cll_pkg::ACT_REMOVE, cll_pkg::ACT_FIRST, cll_pkg::ACT_EMPTY})
			o.empty_res = (nxt[h] == 0);
		return o;
	endfunction

	function void note_request(cll_pkg::req_t r);
		last = predict_action(r);
		expected_rsp.push_back(last);
	endfunction

	function void check_response(cll_pkg::rsp_t a);
		cll_pkg::rsp_t e;
		if (expected_rsp.size() == 0) begin
			$error("response with none pending: node=%0d", a.node);
			errors++;
			return;
		end
		e = expected_rsp.pop_front();
		if (a.node !== e.node) begin
			$error("node: expected %0d, got %0d", e.node, a.node);
			errors++;
		end
		if (a.element !== e.element) begin
			$error("element: expected %h, got %h", e.element, a.element);
			errors++;
		end
		if (a.found !== e.found) begin
			$error("found: expected %0b, got %0b", e.found, a.found);
			errors++;
		end
		if (a.empty_res !== e.empty_res) begin
			$error("empty_res: expected %0b, got %0b", e.empty_res, a.empty_res);
			errors++;
		end
		if (a.status !== e.status) begin
			$error("status: expected %0d, got %0d", e.status, a.status);
			errors++;
		end
	endfunction

	// kind 0: list header, 1: any live node, 2: written live node
	function logic [9:0] pick_node(int kind);
		int s, i;
		s = $urandom_range(1, 1023);
		for (int k = 0; k < 1023; k++) begin
			i = 1 + (s - 1 + k) % 1023;
			if (live[i] && (kind == 1 || (kind == 0 && hdr[i]) || (kind == 2 && written[i])))
				return 10'(i);
		end
		return 10'd0;
	endfunction

	function logic [31:0] pick_value();
		logic [9:0] n;
		n = pick_node(2);
		if (n != 0 && $urandom_range(0, 3) != 0) return elem[n];
		return $urandom();
	endfunction
endclass

module tb_top;
	logic           clk;
	logic           arst_n;
	logic           start;
	cll_pkg::req_t  req;
	logic           busy;
	logic           done;
	cll_pkg::rsp_t  rsp;

	pool_scoreboard sb;
	int burst_left;

	cursor_linked_list_engine dut (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req),
		.busy(busy), .done(done), .rsp(rsp)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#500_000_000;
		$display("status: fail");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && done) sb.check_response(rsp);
	end

	task automatic send(input logic [3:0] act, input logic [9:0] h, input logic [9:0] p,
			input logic [31:0] v);
		cll_pkg::req_t r;
		r.action = act;
		r.list_head = h;
		r.position = p;
		r.value = v;
		start <= 1;
		req <= r;
		do @(posedge clk); while (busy);
		sb.note_request(r);
		if (burst_left > 0) burst_left--;
		else begin
			start <= 0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 8);
		end
	endtask

	task automatic random_request();
		int w;
		logic [9:0] h, p;
		logic [3:0] a;
		w = $urandom_range(0, 99);
		h = sb.pick_node(0);
		if (h == 0 || w < 8) send(cll_pkg::ACT_NEW, $urandom(), $urandom(), $urandom());
		else if (w < 43) begin
			p = ($urandom_range(0, 2) == 0) ? h : sb.pick_node(1);
			send(cll_pkg::ACT_INSERT, $urandom(), p, $urandom());
		end
		else if (w < 55) send(cll_pkg::ACT_FIND, h, $urandom(), sb.pick_value());
		else if (w < 63) send(cll_pkg::ACT_PREV, h, $urandom(), sb.pick_value());
		else if (w < 75) send(cll_pkg::ACT_REMOVE, h, $urandom(), sb.pick_value());
		else if (w < 80) send(cll_pkg::ACT_FIRST, h, $urandom(), $urandom());
		else if (w < 88) send(cll_pkg::ACT_READ, $urandom(), sb.pick_node(2), $urandom());
		else if (w < 91) send(cll_pkg::ACT_EMPTY, h, $urandom(), $urandom());
		else if (w < 94) send(cll_pkg::ACT_DELETE, h, $urandom(), $urandom());
		else if (w < 97) send(4'($urandom_range(9, 15)), $urandom(), $urandom(), $urandom());
		else begin
			a = 4'($urandom_range(2, 8));
			if (a == cll_pkg::ACT_READ) a = cll_pkg::ACT_FIRST;
			send(a, 10'd0, $urandom(), $urandom());
		end
	endtask

	initial begin
		logic [9:0] la, lb, n0, n1;
		int guard;
		sb = new();
		arst_n = 0;
		start = 0;
		req = '0;
		burst_left = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;

		send(cll_pkg::ACT_NEW, 10'd0, 10'd0, 32'd0);
		la = sb.last.node;
		send(cll_pkg::ACT_NEW, 10'h3FF, 10'h3FF, 32'hFFFF_FFFF);
		lb = sb.last.node;
		send(cll_pkg::ACT_FIRST, la, 10'd0, 32'd0);
		send(cll_pkg::ACT_INSERT, 10'd0, la, 32'd0);
		n0 = sb.last.node;
		send(cll_pkg::ACT_INSERT, 10'h3FF, n0, 32'hFFFF_FFFF);
		n1 = sb.last.node;
		send(cll_pkg::ACT_INSERT, la, 10'd0, 32'h1234_5678);
		send(cll_pkg::ACT_INSERT, 10'd0, lb, 32'h8000_0001);
		send(cll_pkg::ACT_FIND, la, 10'd0, 32'hFFFF_FFFF);
		send(cll_pkg::ACT_FIND, la, 10'd0, 32'h5555_AAAA);
		send(cll_pkg::ACT_PREV, la, 10'd0, 32'hFFFF_FFFF);
		send(cll_pkg::ACT_PREV, la, 10'd0, 32'h0BAD_0BAD);
		send(cll_pkg::ACT_READ, 10'd0, n1, 32'd0);
		send(cll_pkg::ACT_READ, 10'd0, 10'd0, 32'd0);
		send(cll_pkg::ACT_REMOVE, la, 10'd0, 32'd0);
		send(cll_pkg::ACT_REMOVE, la, 10'd0, 32'd7);
		send(cll_pkg::ACT_FIRST, la, 10'd0, 32'd0);
		send(cll_pkg::ACT_FIND, 10'd0, 10'd0, 32'd0);
		send(cll_pkg::ACT_PREV, 10'd0, 10'd0, 32'd0);
		send(cll_pkg::ACT_REMOVE, 10'd0, 10'd0, 32'd0);
		send(cll_pkg::ACT_FIRST, 10'd0, 10'd0, 32'd0);
		send(cll_pkg::ACT_EMPTY, 10'd0, 10'd0, 32'd0);
		send(cll_pkg::ACT_DELETE, 10'd0, 10'd0, 32'd0);
		send(4'd15, 10'h3FF, 10'h3FF, 32'hFFFF_FFFF);
		send(cll_pkg::ACT_EMPTY, la, 10'd0, 32'd0);
		send(cll_pkg::ACT_DELETE, lb, 10'd0, 32'd0);

		repeat (700) random_request();

		// exhaust the pool through one long list, then drain it
		send(cll_pkg::ACT_NEW, 10'd0, 10'd0, 32'd0);
		la = sb.last.node;
		guard = 0;
		while (la != 0 && sb.last.status != cll_pkg::ST_FULL && guard < 1100) begin
			send(cll_pkg::ACT_INSERT, 10'd0, la, $urandom());
			guard++;
		end
		send(cll_pkg::ACT_NEW, 10'd0, 10'd0, 32'd0);
		if (la != 0) begin
			send(cll_pkg::ACT_FIND, la, 10'd0, sb.pick_value());
			send(cll_pkg::ACT_REMOVE, la, 10'd0, sb.pick_value());
			send(cll_pkg::ACT_FIND, la, 10'd0, 32'hDEAD_BEEF);
			send(cll_pkg::ACT_EMPTY, la, 10'd0, 32'd0);
			send(cll_pkg::ACT_DELETE, la, 10'd0, 32'd0);
		end

		repeat (150) random_request();
		start <= 0;

		guard = 0;
		while (sb.expected_rsp.size() != 0 && guard < 200_000) begin
			@(posedge clk);
			guard++;
		end
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.expected_rsp.size() == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end
endmodule
